FILE: hw/rtl/sbda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and helpers for the signed BCD decimal ALU
// Operation codes, per-digit lane record, result record, carry prefix.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int DIGITS_DEF = 16;
  localparam int MAX_DIGITS = 16;
  localparam int DATA_W     = 64;
  localparam int KIND_W     = 3;
  localparam int SHIFT_W    = 5;

  localparam int DEC_BASE   = 10;
  localparam int DEC_MAX    = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 3'd0,
    KIND_CMP = 3'd1,
    KIND_SHL = 3'd2,
    KIND_SHR = 3'd3,
    KIND_NEG = 3'd4
  } kind_t;

  // one decimal digit position, as seen by a lane
  typedef struct packed {
    logic [3:0] da;      // clamped digit of a
    logic [3:0] db;      // clamped digit of b
    logic [4:0] sum;     // da + db
    logic       add_g;   // sum >= 10
    logic       add_p;   // sum == 9
    logic       a_lt;    // da < db
    logic       a_gt;    // da > db
    logic       d_eq;    // da == db
  } lane_t;

  typedef struct packed {
    logic              sign;
    logic [DATA_W-1:0] digits;
    logic              ovf;
    logic              lt;
    logic              gt;
    logic              eq;
  } res_t;

  // Kogge-Stone prefix: bit i is the carry out of digit i.
  function automatic logic [MAX_DIGITS-1:0] prefix_carry(
    input logic [MAX_DIGITS-1:0] g,
    input logic [MAX_DIGITS-1:0] p
  );
    logic [MAX_DIGITS-1:0] gg;
    logic [MAX_DIGITS-1:0] pp;
    logic [MAX_DIGITS-1:0] gn;
    logic [MAX_DIGITS-1:0] pn;
    gg = g;
    pp = p;
    for (int d = 1; d < MAX_DIGITS; d = d * 2) begin
      gn = gg;
      pn = pp;
      for (int i = d; i < MAX_DIGITS; i++) begin
        gn[i] = gg[i] | (pp[i] & gg[i-d]);
        pn[i] = pp[i] & pp[i-d];
      end
      gg = gn;
      pp = pn;
    end
    return gg;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sbda_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbda_lane: one decimal digit lane
// Clamps both nibbles to 9 and forms digit sum, carry and compare terms.
// ----------------------------------------------------------------------------
module sbda_lane (
  input  logic           [3:0] a_nib,
  input  logic           [3:0] b_nib,
  output sbda_pkg::lane_t      lane
);
  import sbda_pkg::*;

  logic [3:0] da;
  logic [3:0] db;
  logic [4:0] s;

  // nibbles above 9 read as 9
  assign da = (a_nib > 4'(DEC_MAX)) ? 4'(DEC_MAX) : a_nib;
  assign db = (b_nib > 4'(DEC_MAX)) ? 4'(DEC_MAX) : b_nib;
  assign s  = {1'b0, da} + {1'b0, db};

  always_comb begin
    lane.da    = da;
    lane.db    = db;
    lane.sum   = s;
    lane.add_g = (s >= 5'(DEC_BASE));
    lane.add_p = (s == 5'(DEC_MAX));
    lane.a_lt  = (da < db);
    lane.a_gt  = (da > db);
    lane.d_eq  = (da == db);
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sbda_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbda_merge: combines the digit lanes into one result
// Carry/borrow prefix, final digits, shifts, compare and sign rules.
// ----------------------------------------------------------------------------
module sbda_merge #(
  parameter int DIGITS = sbda_pkg::DIGITS_DEF
) (
  input  sbda_pkg::lane_t       lanes [DIGITS],
  input  sbda_pkg::kind_t       kind,
  input  logic                  a_sign,
  input  logic                  b_sign,
  input  logic [sbda_pkg::SHIFT_W-1:0] shift_count,
  output sbda_pkg::res_t        res
);
  import sbda_pkg::*;

  localparam int DW = 4 * DIGITS;

  logic [MAX_DIGITS-1:0] g_add, p_add, g_ab, g_ba, p_eq, nz_a_v;
  logic [MAX_DIGITS-1:0] c_add, br_ab, br_ba;
  logic [MAX_DIGITS-1:0] cin_add, bin_ab, bin_ba;
  logic [DW-1:0]         am, add_m, ab_m, ba_m, shl_m, shr_m;
  logic                  lost;
  logic                  nz_a, nz_b, as, bs, a_gt_b, a_eq_b;
  logic [6:0]            bit_shift;

  always_comb begin
    g_add  = '0;
    p_add  = '0;
    g_ab   = '0;
    g_ba   = '0;
    p_eq   = '0;
    nz_a_v = '0;
    nz_b   = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      g_add[i]  = lanes[i].add_g;
      p_add[i]  = lanes[i].add_p;
      g_ab[i]   = lanes[i].a_lt;
      g_ba[i]   = lanes[i].a_gt;
      p_eq[i]   = lanes[i].d_eq;
      nz_a_v[i] = (lanes[i].da != 4'd0);
      nz_b      = nz_b | (lanes[i].db != 4'd0);
    end
  end

  assign c_add = prefix_carry(g_add, p_add);
  assign br_ab = prefix_carry(g_ab, p_eq);
  assign br_ba = prefix_carry(g_ba, p_eq);

  assign cin_add = {c_add[MAX_DIGITS-2:0], 1'b0};
  assign bin_ab  = {br_ab[MAX_DIGITS-2:0], 1'b0};
  assign bin_ba  = {br_ba[MAX_DIGITS-2:0], 1'b0};

  assign nz_a   = |nz_a_v;
  assign as     = a_sign & nz_a;
  assign bs     = b_sign & nz_b;
  // b - a borrows out exactly when a > b
  assign a_gt_b = br_ba[DIGITS-1];
  assign a_eq_b = &p_eq[DIGITS-1:0];

  // per-digit finishing, independent across digits
  always_comb begin
    logic [4:0] s;
    logic [4:0] d;
    logic [4:0] e;
    for (int i = 0; i < DIGITS; i++) begin
      am[4*i +: 4] = lanes[i].da;
      s = lanes[i].sum + 5'(cin_add[i]);
      if (s >= 5'(DEC_BASE)) begin
        s = s - 5'(DEC_BASE);
      end
      add_m[4*i +: 4] = s[3:0];
      d = {1'b0, lanes[i].da} - {1'b0, lanes[i].db} - 5'(bin_ab[i]);
      if (d[4]) begin
        d = d + 5'(DEC_BASE);
      end
      ab_m[4*i +: 4] = d[3:0];
      e = {1'b0, lanes[i].db} - {1'b0, lanes[i].da} - 5'(bin_ba[i]);
      if (e[4]) begin
        e = e + 5'(DEC_BASE);
      end
      ba_m[4*i +: 4] = e[3:0];
    end
  end

  // shift-up loses a digit if any nonzero digit sits in the top count positions
  always_comb begin
    lost = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      lost = lost | (nz_a_v[i] && ((6'(i) + 6'(shift_count)) >= 6'(DIGITS)));
    end
  end

  assign bit_shift = {shift_count, 2'b00};
  assign shl_m     = am << bit_shift;
  assign shr_m     = am >> bit_shift;

  always_comb begin
    logic          rs;
    logic [DW-1:0] rm;
    logic          ovf, lt, gt, eq;
    rs  = as;
    rm  = am;
    ovf = 1'b0;
    lt  = 1'b0;
    gt  = 1'b0;
    eq  = 1'b0;
    case (kind)
      KIND_ADD: begin
        if (as == bs) begin
          rm  = add_m;
          ovf = c_add[DIGITS-1];
          rs  = as;
        end else if (a_gt_b) begin
          rm = ab_m;
          rs = as;
        end else begin
          rm = ba_m;
          rs = bs;
        end
      end
      KIND_CMP: begin
        rs = 1'b0;
        rm = '0;
        if (as != bs) begin
          lt = as;
          gt = ~as;
        end else if (a_eq_b) begin
          eq = 1'b1;
        end else if (a_gt_b) begin
          lt = as;
          gt = ~as;
        end else begin
          lt = ~as;
          gt = as;
        end
      end
      KIND_SHL: begin
        if (lost) begin
          ovf = 1'b1;
        end else begin
          rm = shl_m;
        end
      end
      KIND_SHR: begin
        rm = shr_m;
      end
      KIND_NEG: begin
        rs = ~as;
      end
      default: begin
        rs = as;
      end
    endcase
    if (rm == '0) begin
      rs = 1'b0;
    end
    res.sign   = rs;
    res.digits = DATA_W'(rm);
    res.ovf    = ovf;
    res.lt     = lt;
    res.gt     = gt;
    res.eq     = eq;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/signed_bcd_decimal_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_bcd_decimal_alu_core: sign-magnitude packed BCD ALU
// Add, compare, decimal shift up/down and negate on DIGITS-digit numbers.
// ----------------------------------------------------------------------------
// The core takes one item per clock unless the stall below holds the flow,
// and returns one result item for each. In the lane stage a row of DIGITS
// digit lanes works on the item's nibbles (clamp to 9, digit sum, compare
// terms) and its outputs are registered; the merge stage then resolves
// carries and borrows with a log-depth prefix network, finishes the digits,
// applies the shifts and sign rules, and loads the output register. The
// pipeline only stops when out_ready is low and both stages are full; a
// held result stalls the input only once the lane stage behind it is also
// full, and in_ready then follows out_ready combinationally.
// Nibbles above 9 count as 9, digits at and above DIGITS are ignored and
// returned as zero, and a zero result is always positive.
// ----------------------------------------------------------------------------
module signed_bcd_decimal_alu_core #(
  parameter int DIGITS = sbda_pkg::DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sbda_pkg::KIND_W-1:0]   in_kind,
  input  logic                          in_a_sign,
  input  logic [sbda_pkg::DATA_W-1:0]   in_a_digits,
  input  logic                          in_b_sign,
  input  logic [sbda_pkg::DATA_W-1:0]   in_b_digits,
  input  logic [sbda_pkg::SHIFT_W-1:0]  in_shift_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_sign,
  output logic [sbda_pkg::DATA_W-1:0]   out_result_digits,
  output logic                          out_overflow,
  output logic                          out_is_less,
  output logic                          out_is_greater,
  output logic                          out_is_equal
);
  import sbda_pkg::*;

  // lane stage
  lane_t              lane_w [DIGITS];
  lane_t              s1_lane_r [DIGITS];
  kind_t              s1_kind_r;
  logic               s1_a_sign_r;
  logic               s1_b_sign_r;
  logic [SHIFT_W-1:0] s1_shift_r;
  logic               s1_valid_r;

  // output stage
  res_t               merge_res;
  res_t               s2_res_r;
  logic               s2_valid_r;

  logic               s1_adv;
  logic               s2_adv;

  // each stage moves when it is empty or its contents move on
  assign s2_adv   = ~s2_valid_r | out_ready;
  assign s1_adv   = ~s1_valid_r | s2_adv;
  assign in_ready = s1_adv;

  for (genvar gi = 0; gi < DIGITS; gi++) begin : g_lane
    sbda_lane u_lane (
      .a_nib (in_a_digits[4*gi +: 4]),
      .b_nib (in_b_digits[4*gi +: 4]),
      .lane  (lane_w[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_lane_r   <= lane_w;
      s1_kind_r   <= kind_t'(in_kind);
      s1_a_sign_r <= in_a_sign;
      s1_b_sign_r <= in_b_sign;
      s1_shift_r  <= in_shift_count;
    end
  end

  sbda_merge #(
    .DIGITS (DIGITS)
  ) u_merge (
    .lanes       (s1_lane_r),
    .kind        (s1_kind_r),
    .a_sign      (s1_a_sign_r),
    .b_sign      (s1_b_sign_r),
    .shift_count (s1_shift_r),
    .res         (merge_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_res_r <= merge_res;
    end
  end

  assign out_valid         = s2_valid_r;
  assign out_result_sign   = s2_res_r.sign;
  assign out_result_digits = s2_res_r.digits;
  assign out_overflow      = s2_res_r.ovf;
  assign out_is_less       = s2_res_r.lt;
  assign out_is_greater    = s2_res_r.gt;
  assign out_is_equal      = s2_res_r.eq;

  // at most one compare flag, and a compare result carries no magnitude
  a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_is_less, out_is_greater, out_is_equal}))
    else $error("more than one compare flag set");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_is_less || out_is_greater || out_is_equal)
      |-> (out_result_digits == '0) && !out_result_sign && !out_overflow)
    else $error("compare item with nonzero magnitude or flags");

  // zero is never negative, and nothing lives above the digit range
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_digits == '0) |-> !out_result_sign)
    else $error("negative zero on result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_digits >> (4 * DIGITS)) == '0))
    else $error("digit above range is nonzero");

  // a lane-stage item is not dropped while the output is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("lane stage item lost under stall");

endmodule
`default_nettype wire
